// File: rtl/two_point_resistance_identifier_macros.svh
// Assertion macros shared by the two-point resistance identifier RTL.
`ifndef TWO_POINT_RESISTANCE_IDENTIFIER_MACROS_SVH
`define TWO_POINT_RESISTANCE_IDENTIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define TPRI_ASSERT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);
`define TPRI_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TPRI_ASSERT(lbl, clk_s, rst_n_s, ante, cons, msg)
`define TPRI_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg)
`endif
`endif

// File: rtl/tpri_pkg.sv
// Shared types, constants and codes of the two-point resistance identifier.
package tpri_pkg;

	localparam int DIVIDE_TICKS      = 9;
	localparam int STEADY_TICKS      = 1000;
	localparam int HOLD_TICKS        = 20;
	localparam int STEADY_ERROR      = 30;
	localparam int MIN_DELTA_CURRENT = 200;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Width of 1000*dV, of its magnitude (the quotient width) and of |dI|.
	localparam int PROD_W = 27;
	localparam int QUO_W  = 26;
	localparam int DEN_W  = 16;

	localparam logic signed [15:0] RST_FIRST_TARGET  = 16'sd1000;
	localparam logic signed [15:0] RST_SECOND_TARGET = 16'sd2000;
	localparam logic [14:0] RST_HYST_BAND  = 15'd50;
	localparam logic [11:0] RST_FINE_STEP  = 12'd10;
	localparam logic [14:0] RST_VOLT_LIMIT = 15'd3000;
	localparam logic [14:0] RST_DEADTIME   = 15'd200;
	localparam logic [15:0] RST_RES_MIN    = 16'd1;
	localparam logic [15:0] RST_RES_MAX    = 16'd20000;

	typedef enum logic [1:0] {
		ST_RUNNING = 2'd0,
		ST_OK      = 2'd1,
		ST_WEAK    = 2'd2,
		ST_RANGE   = 2'd3
	} meas_status_t;

	typedef enum logic [2:0] {
		REG_FIRST_TARGET  = 3'd0,
		REG_SECOND_TARGET = 3'd1,
		REG_HYST_BAND     = 3'd2,
		REG_FINE_STEP     = 3'd3,
		REG_VOLT_LIMIT    = 3'd4,
		REG_DEADTIME      = 3'd5,
		REG_RES_MIN       = 3'd6,
		REG_RES_MAX       = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] phase_current;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] drive_voltage;
		logic               finished;
		meas_status_t       status;
		logic [15:0]        resistance;
	} out_word_t;

	typedef struct packed {
		logic         latch;
		logic         restart;
		logic         tick;
		logic         hyst;
		logic         vout;
		logic         steady_clear;
		logic         hold_out;
		logic         capture;
		logic         mul;
		logic         div_start;
		logic         fin;
		meas_status_t fin_status;
		logic         out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic div_fire;
		logic near;
		logic steady_reached;
		logic second_phase;
		logic low_delta;
		logic div_done;
		logic in_range;
	} dp_sts_t;

endpackage

// File: rtl/tpri_div.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
`include "two_point_resistance_identifier_macros.svh"
module tpri_div
	import tpri_pkg::*;
#(
	parameter int NUM_BITS = QUO_W,
	parameter int DEN_BITS = DEN_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                done,
	output logic [NUM_BITS-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_BITS + 1);

	logic [DEN_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DEN_BITS:0]   trial_w;

	// The shifted remainder stays below twice the divisor, so the top bit of
	// the difference tells whether the divisor fits.
	assign trial_w = {rem_q, quo_q[NUM_BITS-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q  <= CNT_W'(NUM_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial_w[DEN_BITS]) begin
				rem_q <= trial_w[DEN_BITS-1:0];
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DEN_BITS-2:0], quo_q[NUM_BITS-1]};
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	`TPRI_ASSERT(a_div_no_restart, clk, arst_n, start, !busy_q, "divider restarted while busy")
	`TPRI_ASSERT(a_div_done_follows_busy, clk, arst_n, done_q, $past(busy_q), "divider done without work")
	`TPRI_ASSERT_NEXT(a_div_start_busy, clk, arst_n, start, busy_q, "divider did not start")

endmodule

// File: rtl/tpri_dp.sv
// Datapath: configuration, controller state, capture points, output word.
`include "two_point_resistance_identifier_macros.svh"
module tpri_dp
	import tpri_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  in_word_t               in_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  dp_cmd_t                cmd,
	output dp_sts_t                sts,
	output out_word_t              out_data
);

	function automatic logic signed [15:0] clamp_mv(input logic signed [18:0] v,
	                                               input logic [14:0] lim);
		logic signed [18:0] hi;
		logic signed [18:0] lo;
		hi = $signed({4'b0, lim});
		lo = -hi;
		if (v > hi) clamp_mv = hi[15:0];
		else if (v < lo) clamp_mv = lo[15:0];
		else clamp_mv = v[15:0];
	endfunction

	function automatic logic [16:0] abs17(input logic signed [16:0] v);
		abs17 = v[16] ? $unsigned(-v) : $unsigned(v);
	endfunction

	// Configuration registers
	logic signed [15:0] first_tgt_q, second_tgt_q;
	logic [14:0]        band_q, vlim_q, dtc_q;
	logic [11:0]        fine_q;
	logic [15:0]        rmin_q, rmax_q;

	// Measurement state
	logic [3:0]         div_cnt_q;
	logic [15:0]        steady_q;
	logic [7:0]         hold_q;
	logic signed [15:0] vcmd_q, target_q, held_q;
	logic               phase_q, done_q;
	meas_status_t       status_q;
	logic [15:0]        res_q;

	// Work registers of one item
	logic signed [15:0]       cur_q, vout_q, fpc_q, fpv_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [16:0]       di_q;
	logic                     neg_q;
	out_word_t                out_q;

	logic signed [16:0]       err_w, di_w, dv_w;
	logic [16:0]              abs_err_w, abs_di_w, abs_diq_w;
	logic                     outside_w, err_pos_w, fine_due_w;
	logic [15:0]              coarse_w, step_w;
	logic [7:0]               hold_inc_w;
	logic signed [18:0]       step_s_w, vsum_w, ff_s_w, vff_w;
	logic signed [15:0]       vc_new_w, vout_w;
	logic signed [PROD_W-1:0] dv_ext_w, prod_w;
	logic [PROD_W-1:0]        prod_abs_w;
	logic [QUO_W-1:0]         quo_w;
	logic                     div_done_w, in_range_w;

	assign err_w      = $signed({target_q[15], target_q}) - $signed({cur_q[15], cur_q});
	assign abs_err_w  = abs17(err_w);
	assign outside_w  = abs_err_w > {2'b0, band_q};
	// A zero error steps the command down.
	assign err_pos_w  = !err_w[16] && (err_w != '0);
	assign coarse_w   = ({4'b0, fine_q} << 3) + ({4'b0, fine_q} << 1);
	assign step_w     = outside_w ? coarse_w : {4'b0, fine_q};
	assign hold_inc_w = hold_q + 8'd1;
	assign fine_due_w = hold_inc_w >= 8'(HOLD_TICKS);
	assign step_s_w   = err_pos_w ? $signed({3'b0, step_w}) : -$signed({3'b0, step_w});
	assign vsum_w     = $signed({{3{vcmd_q[15]}}, vcmd_q}) + step_s_w;
	assign vc_new_w   = clamp_mv(vsum_w, vlim_q);

	assign ff_s_w = (!cur_q[15] && (cur_q != '0)) ? $signed({4'b0, dtc_q})
	                                              : -$signed({4'b0, dtc_q});
	assign vff_w  = $signed({{3{vcmd_q[15]}}, vcmd_q}) + ff_s_w;
	assign vout_w = clamp_mv(vff_w, vlim_q);

	assign di_w     = $signed({cur_q[15], cur_q}) - $signed({fpc_q[15], fpc_q});
	assign dv_w     = $signed({vout_q[15], vout_q}) - $signed({fpv_q[15], fpv_q});
	assign abs_di_w = abs17(di_w);
	assign dv_ext_w = {{(PROD_W-17){dv_w[16]}}, dv_w};
	assign prod_w   = dv_ext_w * $signed(PROD_W'(1000));

	assign prod_abs_w = prod_q[PROD_W-1] ? $unsigned(-prod_q) : $unsigned(prod_q);
	assign abs_diq_w  = abs17(di_q);

	tpri_div #(
		.NUM_BITS(QUO_W),
		.DEN_BITS(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (prod_abs_w[QUO_W-1:0]),
		.den   (abs_diq_w[DEN_W-1:0]),
		.done  (div_done_w),
		.quo   (quo_w)
	);

	// A negative nonzero quotient lies below any minimum.
	assign in_range_w = !(neg_q && (quo_w != '0)) && (quo_w >= QUO_W'(rmin_q))
	                    && (quo_w <= QUO_W'(rmax_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_tgt_q  <= RST_FIRST_TARGET;
			second_tgt_q <= RST_SECOND_TARGET;
			band_q       <= RST_HYST_BAND;
			fine_q       <= RST_FINE_STEP;
			vlim_q       <= RST_VOLT_LIMIT;
			dtc_q        <= RST_DEADTIME;
			rmin_q       <= RST_RES_MIN;
			rmax_q       <= RST_RES_MAX;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_FIRST_TARGET:  first_tgt_q  <= $signed(cfg_data);
				REG_SECOND_TARGET: second_tgt_q <= $signed(cfg_data);
				REG_HYST_BAND:     band_q       <= cfg_data[14:0];
				REG_FINE_STEP:     fine_q       <= cfg_data[11:0];
				REG_VOLT_LIMIT:    vlim_q       <= cfg_data[14:0];
				REG_DEADTIME:      dtc_q        <= cfg_data[14:0];
				REG_RES_MIN:       rmin_q       <= cfg_data;
				REG_RES_MAX:       rmax_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			steady_q  <= '0;
			hold_q    <= '0;
			vcmd_q    <= '0;
			target_q  <= RST_FIRST_TARGET;
			phase_q   <= 1'b0;
			held_q    <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_RUNNING;
			res_q     <= '0;
		end else if (cmd.restart) begin
			div_cnt_q <= '0;
			steady_q  <= '0;
			hold_q    <= '0;
			vcmd_q    <= '0;
			target_q  <= first_tgt_q;
			phase_q   <= 1'b0;
			held_q    <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_RUNNING;
			res_q     <= '0;
		end else begin
			if (cmd.tick) begin
				if (steady_q != '1) begin
					steady_q <= steady_q + 16'd1;
				end
				if (div_cnt_q < 4'(DIVIDE_TICKS)) begin
					div_cnt_q <= div_cnt_q + 4'd1;
				end else begin
					div_cnt_q <= '0;
				end
			end
			if (cmd.hyst) begin
				if (outside_w || fine_due_w) begin
					vcmd_q <= vc_new_w;
					hold_q <= '0;
				end else begin
					hold_q <= hold_inc_w;
				end
			end
			if (cmd.steady_clear) begin
				steady_q <= '0;
			end
			if (cmd.hold_out) begin
				held_q <= vout_q;
			end
			if (cmd.capture) begin
				phase_q  <= 1'b1;
				steady_q <= '0;
				target_q <= second_tgt_q;
				vcmd_q   <= '0;
				hold_q   <= '0;
			end
			if (cmd.fin) begin
				done_q   <= 1'b1;
				status_q <= cmd.fin_status;
				res_q    <= (cmd.fin_status == ST_OK) ? quo_w[15:0] : 16'd0;
				held_q   <= '0;
			end
			// While the first point is pending, the active target follows its register.
			if (cfg_we && (reg_index_t'(cfg_index) == REG_FIRST_TARGET) && !phase_q
			    && !done_q) begin
				target_q <= $signed(cfg_data);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cur_q <= in_data.phase_current;
		end
		if (cmd.vout) begin
			vout_q <= vout_w;
		end
		if (cmd.capture) begin
			fpc_q <= cur_q;
			fpv_q <= vout_q;
		end
		if (cmd.mul) begin
			prod_q <= prod_w;
			di_q   <= di_w;
		end
		if (cmd.div_start) begin
			neg_q <= prod_q[PROD_W-1] ^ di_q[16];
		end
		if (cmd.out_load) begin
			out_q <= '{drive_voltage: held_q, finished: done_q, status: status_q,
			           resistance: res_q};
		end
	end

	assign sts.done           = done_q;
	assign sts.div_fire       = !(div_cnt_q < 4'(DIVIDE_TICKS));
	assign sts.near           = abs_err_w < 17'(STEADY_ERROR);
	assign sts.steady_reached = steady_q >= 16'(STEADY_TICKS);
	assign sts.second_phase   = phase_q;
	assign sts.low_delta      = abs_di_w < 17'(MIN_DELTA_CURRENT);
	assign sts.div_done       = div_done_w;
	assign sts.in_range       = in_range_w;

	assign out_data = out_q;

	`TPRI_ASSERT(a_dp_done_zero_out, clk, arst_n, done_q, held_q == '0, "output not zero at end")
	`TPRI_ASSERT(a_dp_status_done, clk, arst_n, 1'b1, (status_q != ST_RUNNING) == done_q, "bad status")
	`TPRI_ASSERT(a_dp_res_ok_only, clk, arst_n, res_q != '0, status_q == ST_OK, "resistance not ok")

endmodule

// File: rtl/tpri_ctrl.sv
// Sequencing state machine that steps one word through the datapath.
module tpri_ctrl
	import tpri_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    item_cmd,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HYST,
		S_VOUT,
		S_EVAL,
		S_DIVGO,
		S_DIV,
		S_RANGE,
		S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.fin_status = ST_RUNNING;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch   = in_valid;
				cmd.restart = in_valid && item_cmd;
				cmd.tick    = in_valid && !item_cmd && !sts.done;
			end
			S_HYST: cmd.hyst = 1'b1;
			S_VOUT: cmd.vout = 1'b1;
			S_EVAL: begin
				if (!sts.near) begin
					cmd.steady_clear = 1'b1;
					cmd.hold_out     = 1'b1;
				end else if (!sts.steady_reached) begin
					cmd.hold_out = 1'b1;
				end else if (!sts.second_phase) begin
					cmd.capture = 1'b1;
				end else if (sts.low_delta) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = ST_WEAK;
				end else begin
					cmd.mul = 1'b1;
				end
			end
			S_DIVGO: cmd.div_start = 1'b1;
			S_DIV: ;
			S_RANGE: begin
				cmd.fin        = 1'b1;
				cmd.fin_status = sts.in_range ? ST_OK : ST_RANGE;
			end
			S_OUT: cmd.out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						// Only every divided tick runs the current controller.
						if (!item_cmd && !sts.done && sts.div_fire) begin
							state_q <= S_HYST;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_HYST: state_q <= S_VOUT;
				S_VOUT: state_q <= S_EVAL;
				S_EVAL: begin
					if (sts.near && sts.steady_reached && sts.second_phase
					    && !sts.low_delta) begin
						state_q <= S_DIVGO;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIVGO: state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_RANGE;
					end
				end
				S_RANGE: state_q <= S_OUT;
				S_OUT: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: rtl/two_point_resistance_identifier.sv
// From acceptance a word goes straight to the output state; when the divided tick runs the
// controller it first passes the hysteresis, output and evaluation states, and on the tick
// that computes the resistance also the divider start, divider and range states. The next
// word is taken in the cycle after the result word is loaded into the output register, never
// before; that register holds a waiting word while the next is taken.
// Reset is asynchronous, active low; it loads the configuration defaults and clears the measurement.
module two_point_resistance_identifier
	import tpri_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_word_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_word_t              out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	tpri_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.item_cmd (in_data.cmd),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tpri_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the two-point resistance identifier with predictor and scoreboard.
module tb_top;
	import tpri_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	in_word_t               in_data = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_word_t              out_data;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	two_point_resistance_identifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the configuration registers.
	int reg_tgt1, reg_tgt2, reg_band, reg_fine, reg_vlim, reg_dead, reg_rmin, reg_rmax;

	// Predicted measurement state.
	int div_cnt, steady_cnt, fine_hold, volt_cmd, act_target, second_phase;
	int point_ma, point_mv, held_mv, meas_done, meas_mohm;
	meas_status_t meas_st;

	in_word_t  word_q[$];
	out_word_t expected_q[$];
	int        words_queued = 0;
	int        words_taken = 0;
	int        errors = 0;
	int        hold_left = 0;
	bit        holdoff_req = 1'b0;

	function automatic bit quiet();
		return (($time / 10) % 8192) >= 6144;
	endfunction

	function automatic int mag(int v);
		return v < 0 ? -v : v;
	endfunction

	function automatic int clip16(int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic int rand16();
		return int'($urandom_range(65535)) - 32768;
	endfunction

	function automatic int clamp_mv(int v);
		if (v > reg_vlim) return reg_vlim;
		if (v < -reg_vlim) return -reg_vlim;
		return v;
	endfunction

	task clear_measurement();
		div_cnt = 0;
		steady_cnt = 0;
		fine_hold = 0;
		volt_cmd = 0;
		act_target = reg_tgt1;
		second_phase = 0;
		point_ma = 0;
		point_mv = 0;
		held_mv = 0;
		meas_done = 0;
		meas_st = ST_RUNNING;
		meas_mohm = 0;
	endtask

	task end_measurement(input meas_status_t st, input int mohm);
		meas_done = 1;
		meas_st = st;
		meas_mohm = mohm;
		held_mv = 0;
	endtask

	task run_controller(input int cur);
		int err, vout, di, dv, ratio;
		err = act_target - cur;
		if (mag(err) > reg_band) begin
			volt_cmd = clamp_mv(volt_cmd + (err > 0 ? 10 * reg_fine : -10 * reg_fine));
			fine_hold = 0;
		end else begin
			fine_hold = (fine_hold + 1) & 'hFF;
			// A zero error steps the command down.
			if (fine_hold >= HOLD_TICKS) begin
				volt_cmd = clamp_mv(volt_cmd + (err > 0 ? reg_fine : -reg_fine));
				fine_hold = 0;
			end
		end
		vout = clamp_mv(volt_cmd + (cur > 0 ? reg_dead : -reg_dead));
		if (mag(cur - act_target) >= STEADY_ERROR) begin
			steady_cnt = 0;
			held_mv = vout;
		end else if (steady_cnt < STEADY_TICKS) begin
			held_mv = vout;
		end else if (!second_phase) begin
			// The held output keeps its old value on the capture tick.
			point_ma = cur;
			point_mv = vout;
			second_phase = 1;
			steady_cnt = 0;
			act_target = reg_tgt2;
			volt_cmd = 0;
			fine_hold = 0;
		end else begin
			di = cur - point_ma;
			dv = vout - point_mv;
			if (mag(di) < MIN_DELTA_CURRENT) begin
				end_measurement(ST_WEAK, 0);
			end else begin
				ratio = (dv * 1000) / di;
				if (ratio < reg_rmin || ratio > reg_rmax)
					end_measurement(ST_RANGE, 0);
				else
					end_measurement(ST_OK, ratio > 65535 ? 65535 : ratio);
			end
		end
	endtask

	task step_identifier(input in_word_t w, output out_word_t o);
		if (w.cmd) begin
			clear_measurement();
		end else if (!meas_done) begin
			if (steady_cnt < 65535) steady_cnt++;
			if (div_cnt < DIVIDE_TICKS) begin
				div_cnt++;
			end else begin
				div_cnt = 0;
				run_controller($signed(w.phase_current));
			end
		end
		o.drive_voltage = held_mv[15:0];
		o.finished = meas_done[0];
		o.status = meas_st;
		o.resistance = meas_mohm[15:0];
	endtask

	task write_reg(input reg_index_t idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		case (idx)
			REG_FIRST_TARGET: begin
				reg_tgt1 = $signed(val[15:0]);
				if (!second_phase && !meas_done) act_target = reg_tgt1;
			end
			REG_SECOND_TARGET: reg_tgt2 = $signed(val[15:0]);
			REG_HYST_BAND:     reg_band = val & 'h7FFF;
			REG_FINE_STEP:     reg_fine = val & 'hFFF;
			REG_VOLT_LIMIT:    reg_vlim = val & 'h7FFF;
			REG_DEADTIME:      reg_dead = val & 'h7FFF;
			REG_RES_MIN:       reg_rmin = val & 'hFFFF;
			REG_RES_MAX:       reg_rmax = val & 'hFFFF;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task send(input bit cmd, input int cur);
		in_word_t w;
		w.cmd = cmd;
		w.phase_current = 16'(clip16(cur));
		word_q.push_back(w);
		words_queued++;
	endtask

	task wait_idle();
		while (words_taken != words_queued || expected_q.size() != 0) @(posedge clk);
	endtask

	task load_config(input int t1, input int t2, input int band, input int fine,
			input int vlim, input int dead, input int rmin, input int rmax);
		wait_idle();
		write_reg(REG_FIRST_TARGET, t1);
		write_reg(REG_SECOND_TARGET, t2);
		write_reg(REG_HYST_BAND, band);
		write_reg(REG_FINE_STEP, fine);
		write_reg(REG_VOLT_LIMIT, vlim);
		write_reg(REG_DEADTIME, dead);
		write_reg(REG_RES_MIN, rmin);
		write_reg(REG_RES_MAX, rmax);
	endtask

	task noise(input int count);
		send(1'b1, rand16());
		repeat (count) send($urandom_range(99) < 3, rand16());
	endtask

	// Current held near the target; a few early outliers break the steady count.
	task settle(input int target, input int amp, input int count);
		int k, off;
		for (k = 0; k < count; k++) begin
			if (k < 10 && $urandom_range(99) < 20)
				off = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(200, STEADY_ERROR));
			else
				off = int'($urandom_range(2 * amp)) - amp;
			send(1'b0, target + off);
		end
	endtask

	// One full measurement: restart, approach, first point, second point, idle ticks.
	task measure(input int amp, input bit mid_writes);
		int ramp, k, off;
		holdoff_req = 1'b1;
		send(1'b1, rand16());
		ramp = $urandom_range(40);
		for (k = 0; k < ramp; k++) begin
			off = $urandom_range(5000, 100);
			send(1'b0, $urandom_range(99) < 70 ? reg_tgt1 - off : reg_tgt1 + off);
		end
		if (mid_writes) begin
			// Still in the first phase, so the new first target applies at once.
			wait_idle();
			write_reg(REG_FIRST_TARGET, clip16(reg_tgt1 + int'($urandom_range(600)) - 300));
			write_reg(REG_SECOND_TARGET, reg_tgt2);
		end
		settle(reg_tgt1, amp, 1030);
		settle(reg_tgt2, amp, 500);
		if (mid_writes) begin
			// Second phase: this write must not disturb the active target.
			wait_idle();
			write_reg(REG_FIRST_TARGET, rand16());
		end
		settle(reg_tgt2, amp, 540);
		repeat (10) send(1'b0, rand16());
	endtask

	always @(posedge clk) begin : drive_proc
		out_word_t predicted;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				step_identifier(in_data, predicted);
				expected_q.push_back(predicted);
				words_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (word_q.size() != 0 && (quiet() || $urandom_range(99) >= 28)) begin
					in_valid <= 1'b1;
					in_data <= word_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_proc
		out_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: result word %h with nothing expected", $time, out_data);
				end else begin
					want = expected_q.pop_front();
					if (out_data.drive_voltage !== want.drive_voltage) begin
						errors++;
						$display("%0t: drive_voltage expected %0d, got %0d", $time,
							want.drive_voltage, out_data.drive_voltage);
					end
					if (out_data.finished !== want.finished) begin
						errors++;
						$display("%0t: finished expected %b, got %b", $time,
							want.finished, out_data.finished);
					end
					if (out_data.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d, got %0d", $time,
							want.status, out_data.status);
					end
					if (out_data.resistance !== want.resistance) begin
						errors++;
						$display("%0t: resistance expected %0d, got %0d", $time,
							want.resistance, out_data.resistance);
					end
				end
			end
			// A long hold-off lets the sender run into a full block.
			if (holdoff_req) begin
				hold_left = 300;
				holdoff_req = 1'b0;
			end
			if (hold_left > 0) hold_left--;
			out_stall <= hold_left > 0 || (!quiet() && $urandom_range(99) < 28);
		end
	end

	initial begin
		#10000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		reg_tgt1 = RST_FIRST_TARGET;
		reg_tgt2 = RST_SECOND_TARGET;
		reg_band = RST_HYST_BAND;
		reg_fine = RST_FINE_STEP;
		reg_vlim = RST_VOLT_LIMIT;
		reg_dead = RST_DEADTIME;
		reg_rmin = RST_RES_MIN;
		reg_rmax = RST_RES_MAX;
		clear_measurement();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Field extremes, a controller tick at zero error, then restarts.
		send(1'b0, 32767);
		send(1'b0, -32768);
		send(1'b0, 0);
		send(1'b0, -1);
		send(1'b0, 1);
		send(1'b0, 21845);
		send(1'b0, -21846);
		repeat (3) send(1'b0, 1000);
		repeat (9) send(1'b0, 32767);
		send(1'b0, -32768);
		send(1'b1, -32768);
		send(1'b1, 32767);
		send(1'b0, 0);
		send(1'b0, 1000);

		load_config(-32768, 32767, 0, 3000, 32767, 32767, 0, 65535);
		noise(30);
		load_config(800, 2500, 40, 25, 6000, 300, 0, 65535);
		measure(10, 1'b1);

		wait_idle();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
